// ----- src/lrast_pkg.sv -----
// lrast_pkg: shared types, constants and helper functions for the line rasterizer
// used by the front, queue, back and top level modules; no dependencies
`timescale 1ns / 1ps

package lrast_pkg;

  localparam int COORD_BITS = 9;
  localparam int ERR_BITS   = COORD_BITS + 1;
  localparam int COLOR_BITS = 16;
  localparam int QDEPTH     = 2;
  localparam int QAW        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW        = $clog2(QDEPTH + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_POS  = 2'd1;
  localparam logic [1:0] STEP_NEG  = 2'd3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ERR_BITS-1:0]   err_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef struct packed {
    logic       op;
    coord_t     x_start;
    coord_t     y_start;
    coord_t     abs_dx;
    coord_t     abs_dy;
    coord_t     major;
    logic [1:0] step_x;
    logic [1:0] step_y;
    color_t     color;
  } lrast_item_t;

  function automatic coord_t axis_move(coord_t pos, logic [1:0] dir);
    coord_t res;
    case (dir)
      STEP_POS: res = pos + coord_t'(1);
      STEP_NEG: res = pos - coord_t'(1);
      default:  res = pos;
    endcase
    return res;
  endfunction

endpackage

// ----- src/line_rasterizer_core.sv -----
// line_rasterizer_core: top level of the line rasterizer
// a step request passes through the queue and then the output register before its point shows
// throughput: one request per cycle unless stalled, set by the accumulator update in the back
// the two-entry request queue lets input and output stall independently
// reset (synchronous, rst_n low) empties the queue, drops the output and leaves the block idle
`timescale 1ns / 1ps

module line_rasterizer_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  lrast_pkg::coord_t in_x_start,
  input  lrast_pkg::coord_t in_y_start,
  input  lrast_pkg::coord_t in_x_end,
  input  lrast_pkg::coord_t in_y_end,
  input  lrast_pkg::color_t in_color,
  output logic              out_valid,
  input  logic              out_ready,
  output lrast_pkg::coord_t out_x,
  output lrast_pkg::coord_t out_y,
  output lrast_pkg::color_t out_pixel_color,
  output logic              out_last_point
);

  logic                   q_ready;
  logic                   q_push;
  logic                   q_valid;
  logic                   q_pop;
  lrast_pkg::lrast_item_t push_item;
  lrast_pkg::lrast_item_t head_item;

  lrast_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_x_start (in_x_start),
    .in_y_start (in_y_start),
    .in_x_end   (in_x_end),
    .in_y_end   (in_y_end),
    .in_color   (in_color),
    .q_ready    (q_ready),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  lrast_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .not_full  (q_ready),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_item (head_item)
  );

  lrast_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (head_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_pixel_color (out_pixel_color),
    .out_last_point  (out_last_point)
  );

endmodule

// ----- src/lrast_front.sv -----
// lrast_front: accepts requests and classifies them, working out deltas,
// step directions and major distance for loads; depends on lrast_pkg
`timescale 1ns / 1ps

module lrast_front (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  lrast_pkg::coord_t     in_x_start,
  input  lrast_pkg::coord_t     in_y_start,
  input  lrast_pkg::coord_t     in_x_end,
  input  lrast_pkg::coord_t     in_y_end,
  input  lrast_pkg::color_t     in_color,
  input  logic                  q_ready,
  output logic                  q_push,
  output lrast_pkg::lrast_item_t q_item
);

  lrast_pkg::coord_t adx;
  lrast_pkg::coord_t ady;
  logic [1:0]        sx;
  logic [1:0]        sy;

  always_comb begin
    if (in_x_end > in_x_start) begin
      adx = in_x_end - in_x_start;
      sx  = lrast_pkg::STEP_POS;
    end else if (in_x_end < in_x_start) begin
      adx = in_x_start - in_x_end;
      sx  = lrast_pkg::STEP_NEG;
    end else begin
      adx = '0;
      sx  = lrast_pkg::STEP_NONE;
    end
    if (in_y_end > in_y_start) begin
      ady = in_y_end - in_y_start;
      sy  = lrast_pkg::STEP_POS;
    end else if (in_y_end < in_y_start) begin
      ady = in_y_start - in_y_end;
      sy  = lrast_pkg::STEP_NEG;
    end else begin
      ady = '0;
      sy  = lrast_pkg::STEP_NONE;
    end
  end

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  always_comb begin
    q_item.op      = in_op;
    q_item.x_start = in_x_start;
    q_item.y_start = in_y_start;
    q_item.abs_dx  = adx;
    q_item.abs_dy  = ady;
    q_item.major   = (adx > ady) ? adx : ady;
    q_item.step_x  = sx;
    q_item.step_y  = sy;
    q_item.color   = in_color;
  end

endmodule

// ----- src/lrast_queue.sv -----
// lrast_queue: short fifo of classified requests between front and back
// depends on lrast_pkg
`timescale 1ns / 1ps

module lrast_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  lrast_pkg::lrast_item_t push_item,
  output logic                   not_full,
  input  logic                   pop,
  output logic                   not_empty,
  output lrast_pkg::lrast_item_t head_item
);

  lrast_pkg::lrast_item_t         mem_r [lrast_pkg::QDEPTH];
  logic [lrast_pkg::QAW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [lrast_pkg::QAW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [lrast_pkg::QCW-1:0]      count_r, count_nxt;

  localparam logic [lrast_pkg::QAW-1:0] PTR_LAST = lrast_pkg::QAW'(lrast_pkg::QDEPTH - 1);
  localparam logic [lrast_pkg::QCW-1:0] CNT_FULL = lrast_pkg::QCW'(lrast_pkg::QDEPTH);

  assign not_full  = (count_r != CNT_FULL);
  assign not_empty = (count_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- src/lrast_back.sv -----
// lrast_back: line state, error accumulators and the output register
// depends on lrast_pkg
`timescale 1ns / 1ps

module lrast_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  lrast_pkg::lrast_item_t q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lrast_pkg::coord_t      out_x,
  output lrast_pkg::coord_t      out_y,
  output lrast_pkg::color_t      out_pixel_color,
  output logic                   out_last_point
);

  lrast_pkg::coord_t cur_x_r, cur_x_nxt;
  lrast_pkg::coord_t cur_y_r, cur_y_nxt;
  lrast_pkg::coord_t abs_dx_r, abs_dx_nxt;
  lrast_pkg::coord_t abs_dy_r, abs_dy_nxt;
  lrast_pkg::coord_t major_r, major_nxt;
  logic [1:0]        step_x_r, step_x_nxt;
  logic [1:0]        step_y_r, step_y_nxt;
  lrast_pkg::err_t   err_x_r, err_x_nxt;
  lrast_pkg::err_t   err_y_r, err_y_nxt;
  lrast_pkg::err_t   left_r, left_nxt;
  logic              busy_r, busy_nxt;
  lrast_pkg::color_t color_r, color_nxt;

  logic              out_valid_r, out_valid_nxt;
  lrast_pkg::coord_t out_x_r, out_x_nxt;
  lrast_pkg::coord_t out_y_r, out_y_nxt;
  lrast_pkg::color_t out_color_r, out_color_nxt;
  logic              out_last_r, out_last_nxt;

  lrast_pkg::err_t   ex_sum;
  lrast_pkg::err_t   ey_sum;
  lrast_pkg::err_t   major_ext;
  lrast_pkg::err_t   left_dec;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign major_ext = {1'b0, major_r};
  assign ex_sum    = err_x_r + {1'b0, abs_dx_r};
  assign ey_sum    = err_y_r + {1'b0, abs_dy_r};
  assign left_dec  = (left_r != '0) ? left_r - 1'b1 : left_r;

  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    abs_dx_nxt    = abs_dx_r;
    abs_dy_nxt    = abs_dy_r;
    major_nxt     = major_r;
    step_x_nxt    = step_x_r;
    step_y_nxt    = step_y_r;
    err_x_nxt     = err_x_r;
    err_y_nxt     = err_y_r;
    left_nxt      = left_r;
    busy_nxt      = busy_r;
    color_nxt     = color_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      if (q_item.op == lrast_pkg::OP_LOAD) begin
        cur_x_nxt  = q_item.x_start;
        cur_y_nxt  = q_item.y_start;
        abs_dx_nxt = q_item.abs_dx;
        abs_dy_nxt = q_item.abs_dy;
        major_nxt  = q_item.major;
        step_x_nxt = q_item.step_x;
        step_y_nxt = q_item.step_y;
        err_x_nxt  = '0;
        err_y_nxt  = '0;
        left_nxt   = {1'b0, q_item.major} + lrast_pkg::err_t'(2);
        busy_nxt   = 1'b1;
        color_nxt  = q_item.color;
      end else if (busy_r) begin
        out_valid_nxt = 1'b1;
        out_x_nxt     = cur_x_r;
        out_y_nxt     = cur_y_r;
        out_color_nxt = color_r;
        out_last_nxt  = (left_r == lrast_pkg::err_t'(1));
        err_x_nxt     = ex_sum;
        err_y_nxt     = ey_sum;
        if (ex_sum > major_ext) begin
          err_x_nxt = ex_sum - major_ext;
          cur_x_nxt = lrast_pkg::axis_move(cur_x_r, step_x_r);
        end
        if (ey_sum > major_ext) begin
          err_y_nxt = ey_sum - major_ext;
          cur_y_nxt = lrast_pkg::axis_move(cur_y_r, step_y_r);
        end
        left_nxt = left_dec;
        busy_nxt = (left_dec != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r     <= cur_x_nxt;
    cur_y_r     <= cur_y_nxt;
    abs_dx_r    <= abs_dx_nxt;
    abs_dy_r    <= abs_dy_nxt;
    major_r     <= major_nxt;
    step_x_r    <= step_x_nxt;
    step_y_r    <= step_y_nxt;
    err_x_r     <= err_x_nxt;
    err_y_r     <= err_y_nxt;
    color_r     <= color_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_x           = out_x_r;
  assign out_y           = out_y_r;
  assign out_pixel_color = out_color_r;
  assign out_last_point  = out_last_r;

endmodule

// ----- src/lrast_checker.sv -----
// lrast_checker: port-level assertions for line_rasterizer_core
// depends on lrast_pkg; attached to the top level by the bind below
`timescale 1ns / 1ps

module lrast_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input lrast_pkg::coord_t out_x,
  input lrast_pkg::coord_t out_y,
  input lrast_pkg::color_t out_pixel_color,
  input logic              out_last_point
);

  a_reset_no_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_pixel_color) && $stable(out_last_point))
    else $error("stalled output changed");

  a_ready_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready && out_ready |=> in_ready)
    else $error("input stuck while output drains");

endmodule

bind line_rasterizer_core lrast_checker u_lrast_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_x           (out_x),
  .out_y           (out_y),
  .out_pixel_color (out_pixel_color),
  .out_last_point  (out_last_point)
);

// ----- verif/line_rasterizer_checker.sv -----
// line_rasterizer_checker: watches the request and point channels of line_rasterizer_core,
// predicts every point from the accepted requests and compares field by field
// depends on lrast_pkg for coordinate and color types and op/step codes
`timescale 1ns / 1ps

module line_rasterizer_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_op,
  input  lrast_pkg::coord_t in_x_start,
  input  lrast_pkg::coord_t in_y_start,
  input  lrast_pkg::coord_t in_x_end,
  input  lrast_pkg::coord_t in_y_end,
  input  lrast_pkg::color_t in_color,
  input  logic              out_valid,
  input  logic              out_ready,
  input  lrast_pkg::coord_t out_x,
  input  lrast_pkg::coord_t out_y,
  input  lrast_pkg::color_t out_pixel_color,
  input  logic              out_last_point,
  output int                mismatches,
  output int                pending,
  output int                points_checked
);

  typedef struct packed {
    lrast_pkg::coord_t x;
    lrast_pkg::coord_t y;
    lrast_pkg::color_t color;
    logic              last;
  } point_t;

  point_t            expected_points[$];
  lrast_pkg::coord_t cur_x, cur_y, abs_dx, abs_dy, major;
  logic [1:0]        step_x, step_y;
  lrast_pkg::err_t   err_x, err_y;
  logic [9:0]        points_left;
  logic              busy;
  lrast_pkg::color_t line_color;
  int                fail_count;
  int                checked_count;

  function automatic void span(input lrast_pkg::coord_t from, input lrast_pkg::coord_t to,
                               output lrast_pkg::coord_t delta, output logic [1:0] dir);
    if (to > from) begin
      delta = to - from;
      dir   = lrast_pkg::STEP_POS;
    end else if (to < from) begin
      delta = from - to;
      dir   = lrast_pkg::STEP_NEG;
    end else begin
      delta = '0;
      dir   = lrast_pkg::STEP_NONE;
    end
  endfunction

  function automatic lrast_pkg::coord_t walk(lrast_pkg::coord_t pos, logic [1:0] dir);
    if (dir == lrast_pkg::STEP_POS) return pos + lrast_pkg::coord_t'(1);
    if (dir == lrast_pkg::STEP_NEG) return pos - lrast_pkg::coord_t'(1);
    return pos;
  endfunction

  task automatic report(string what, int unsigned want, int unsigned got);
    $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
    fail_count++;
  endtask

  task automatic predict_request(logic op, lrast_pkg::coord_t xs, lrast_pkg::coord_t ys,
                                 lrast_pkg::coord_t xe, lrast_pkg::coord_t ye,
                                 lrast_pkg::color_t col);
    point_t p;
    if (op == lrast_pkg::OP_LOAD) begin
      cur_x = xs;
      cur_y = ys;
      line_color = col;
      span(xs, xe, abs_dx, step_x);
      span(ys, ye, abs_dy, step_y);
      major = (abs_dx > abs_dy) ? abs_dx : abs_dy;
      err_x = '0;
      err_y = '0;
      points_left = {1'b0, major} + 10'd2;
      busy = 1'b1;
    end else if (busy) begin
      p.x = cur_x;
      p.y = cur_y;
      p.color = line_color;
      p.last = (points_left == 10'd1);
      expected_points.push_back(p);
      err_x = err_x + lrast_pkg::err_t'(abs_dx);
      err_y = err_y + lrast_pkg::err_t'(abs_dy);
      if (err_x > lrast_pkg::err_t'(major)) begin
        err_x = err_x - lrast_pkg::err_t'(major);
        cur_x = walk(cur_x, step_x);
      end
      if (err_y > lrast_pkg::err_t'(major)) begin
        err_y = err_y - lrast_pkg::err_t'(major);
        cur_y = walk(cur_y, step_y);
      end
      if (points_left != 10'd0) points_left = points_left - 10'd1;
      if (points_left == 10'd0) busy = 1'b0;
    end
  endtask

  task automatic check_point(lrast_pkg::coord_t x, lrast_pkg::coord_t y,
                             lrast_pkg::color_t col, logic last);
    point_t want;
    if (expected_points.size() == 0) begin
      report("point with nothing pending, x", 0, x);
      return;
    end
    want = expected_points.pop_front();
    checked_count++;
    if (x !== want.x) report("x", want.x, x);
    if (y !== want.y) report("y", want.y, y);
    if (col !== want.color) report("pixel_color", want.color, col);
    if (last !== want.last) report("last_point", want.last, last);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_x = '0;
      cur_y = '0;
      abs_dx = '0;
      abs_dy = '0;
      major = '0;
      step_x = lrast_pkg::STEP_NONE;
      step_y = lrast_pkg::STEP_NONE;
      err_x = '0;
      err_y = '0;
      points_left = '0;
      busy = 1'b0;
      line_color = '0;
      expected_points.delete();
    end else begin
      if (out_valid && out_ready) check_point(out_x, out_y, out_pixel_color, out_last_point);
      if (in_valid && in_ready)
        predict_request(in_op, in_x_start, in_y_start, in_x_end, in_y_end, in_color);
    end
    mismatches <= fail_count;
    pending <= expected_points.size();
    points_checked <= checked_count;
  end

endmodule

// ----- verif/tb.sv -----
// tb: drives line_rasterizer_core with directed and random line requests under random idling
// depends on lrast_pkg, line_rasterizer_core and line_rasterizer_checker
`timescale 1ns / 1ps

module tb;

  localparam int COORD_MAX  = (1 << lrast_pkg::COORD_BITS) - 1;
  localparam int ITEM_GOAL  = 1050;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_op;
  lrast_pkg::coord_t in_x_start, in_y_start, in_x_end, in_y_end;
  lrast_pkg::color_t in_color;
  logic              out_valid;
  logic              out_ready;
  lrast_pkg::coord_t out_x, out_y;
  lrast_pkg::color_t out_pixel_color;
  logic              out_last_point;

  int mismatches;
  int pending;
  int points_checked;
  int sent;
  int quiet_cycles;
  bit gaps_on;
  bit hold_req;

  line_rasterizer_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_x_start(in_x_start), .in_y_start(in_y_start),
    .in_x_end(in_x_end), .in_y_end(in_y_end), .in_color(in_color),
    .out_valid(out_valid), .out_ready(out_ready), .out_x(out_x), .out_y(out_y),
    .out_pixel_color(out_pixel_color), .out_last_point(out_last_point)
  );

  line_rasterizer_checker point_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_x_start(in_x_start), .in_y_start(in_y_start),
    .in_x_end(in_x_end), .in_y_end(in_y_end), .in_color(in_color),
    .out_valid(out_valid), .out_ready(out_ready), .out_x(out_x), .out_y(out_y),
    .out_pixel_color(out_pixel_color), .out_last_point(out_last_point),
    .mismatches(mismatches), .pending(pending), .points_checked(points_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_request(logic op, lrast_pkg::coord_t xs, lrast_pkg::coord_t ys,
                              lrast_pkg::coord_t xe, lrast_pkg::coord_t ye,
                              lrast_pkg::color_t col);
    while (gaps_on && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_x_start <= xs;
    in_y_start <= ys;
    in_x_end <= xe;
    in_y_end <= ye;
    in_color <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // step fields are don't-care, so fill them with noise
  task automatic step_point();
    send_request(lrast_pkg::OP_STEP, lrast_pkg::coord_t'($urandom),
                 lrast_pkg::coord_t'($urandom), lrast_pkg::coord_t'($urandom),
                 lrast_pkg::coord_t'($urandom), lrast_pkg::color_t'($urandom));
  endtask

  function automatic lrast_pkg::coord_t offset_coord(lrast_pkg::coord_t from, int dist_val);
    int v;
    v = int'(from) + dist_val;
    if (v < 0 || v > COORD_MAX) v = int'(from) - dist_val;
    return lrast_pkg::coord_t'(v);
  endfunction

  task automatic random_line(int reach, int room);
    lrast_pkg::coord_t xs, ys, xe, ye;
    int                dx, dy, major, steps, pick;
    xs = lrast_pkg::coord_t'($urandom_range(0, COORD_MAX));
    ys = lrast_pkg::coord_t'($urandom_range(0, COORD_MAX));
    xe = offset_coord(xs, $urandom_range(0, 1) ? $urandom_range(0, reach)
                                               : -$urandom_range(0, reach));
    ye = offset_coord(ys, $urandom_range(0, 1) ? $urandom_range(0, reach)
                                               : -$urandom_range(0, reach));
    dx = (xe > xs) ? xe - xs : xs - xe;
    dy = (ye > ys) ? ye - ys : ys - ye;
    major = (dx > dy) ? dx : dy;
    pick = $urandom_range(0, 99);
    if (pick < 75) steps = major + 2;
    else if (pick < 85) steps = $urandom_range(0, major + 1);
    else steps = major + 2 + $urandom_range(1, 3);
    if (steps > room - 1) steps = room - 1;
    send_request(lrast_pkg::OP_LOAD, xs, ys, xe, ye, lrast_pkg::color_t'($urandom));
    repeat (steps) step_point();
  endtask

  task automatic random_phase(int goal);
    while (sent < goal) begin
      if ($urandom_range(0, 99) < 10)
        send_request(logic'($urandom_range(0, 1)), lrast_pkg::coord_t'($urandom),
                     lrast_pkg::coord_t'($urandom), lrast_pkg::coord_t'($urandom),
                     lrast_pkg::coord_t'($urandom), lrast_pkg::color_t'($urandom));
      else if ($urandom_range(0, 24) == 0)
        random_line(COORD_MAX, goal - sent);
      else
        random_line(12, goal - sent);
    end
  endtask

  // receiver
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= !(gaps_on && $urandom_range(0, 99) < 29);
      end
    end
  end

  // stall watchdog
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no request or point moved for %0d cycles", STALL_LIMIT);
        $display("FAIL line_rasterizer_core");
        $finish;
      end
    end
  end

  initial begin
    sent = 0;
    gaps_on = 1'b1;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= lrast_pkg::OP_LOAD;
    in_x_start <= '0;
    in_y_start <= '0;
    in_x_end <= '0;
    in_y_end <= '0;
    in_color <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // step while idle, then a single-point line and a step past its end
    step_point();
    send_request(lrast_pkg::OP_LOAD, 9'd0, 9'd0, 9'd0, 9'd0, 16'h0000);
    repeat (3) step_point();
    // full diagonal down to the origin, dropped by a new load
    send_request(lrast_pkg::OP_LOAD, 9'd511, 9'd511, 9'd0, 9'd0, 16'hffff);
    repeat (3) step_point();
    send_request(lrast_pkg::OP_LOAD, 9'd511, 9'd0, 9'd0, 9'd511, 16'h5555);
    repeat (2) step_point();
    // shallow line with falling y, run to the end and one step beyond
    send_request(lrast_pkg::OP_LOAD, 9'd3, 9'd7, 9'd9, 9'd4, 16'haaaa);
    repeat (9) step_point();
    send_request(lrast_pkg::OP_LOAD, 9'd100, 9'd200, 9'd102, 9'd190, 16'h1234);

    random_phase(350);
    gaps_on = 1'b0;
    random_phase(650);

    // output held off while requests keep coming
    hold_req = 1'b1;
    send_request(lrast_pkg::OP_LOAD, 9'd10, 9'd20, 9'd130, 9'd60, 16'hbeef);
    repeat (122) step_point();
    gaps_on = 1'b1;
    random_phase(ITEM_GOAL);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("ran %0d requests (loads, steps, idle steps, restarts), %0d points checked",
             sent, points_checked);
    $display("idling: random gaps on both sides, one gap-free stretch, one long output stall");
    if (mismatches == 0 && pending == 0) begin
      $display("PASS line_rasterizer_core");
    end else begin
      $display("FAIL line_rasterizer_core");
    end
    $finish;
  end

endmodule
